[sv/upd_pkg.sv]
`default_nettype none
package upd_pkg;

    typedef enum logic [2:0] {
        ST_EMPTY,
        ST_PCT,
        ST_PCT_D,
        ST_NL,
        ST_NL_PCT,
        ST_NL_PCT0
    } state_t;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_D  = 8'h44;

    localparam logic [2:0] RES_MAX  = 3'd4;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
        logic            last;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } code_t;

    function automatic logic [7:0] map_plain(logic [7:0] b);
        return (b == CH_PLUS) ? CH_SPACE : b;
    endfunction

    function automatic logic is_code_start(logic [7:0] b);
        return (b == CH_ZERO) || (b >= 8'h32 && b <= 8'h37);
    endfunction

    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic code_t known_code(logic [7:0] hi, logic [7:0] lo);
        code_t      r;
        logic [4:0] h;
        logic [4:0] l;
        h = hex_val(hi);
        l = hex_val(lo);
        r.val = {h[3:0], l[3:0]};
        r.ok  = 1'b0;
        if (!h[4] && !l[4]) begin
            r.ok = (r.val >= 8'h20 && r.val <= 8'h2F) ||
                   (r.val >= 8'h3A && r.val <= 8'h40) ||
                   (r.val >= 8'h5B && r.val <= 8'h60) ||
                   (r.val >= 8'h7B && r.val <= 8'h7E) ||
                   (r.val == CH_CR) || (r.val == CH_NL);
        end
        return r;
    endfunction

    function automatic res_t res_push(res_t r, logic [7:0] b);
        res_t t;
        t = r;
        if (r.cnt != RES_MAX) begin
            t.bytes[r.cnt[1:0]] = b;
            t.cnt               = r.cnt + 3'd1;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

[sv/url_percent_decoder_top.sv]
`default_nettype none
// URL percent decoder.
// Input channel (in_valid/in_ready): one encoded byte per request, in_last on
// the final byte of a string. Output channel (out_valid/out_ready): decoded
// bytes, out_last on the final decoded byte of the string.
// '+' -> space, %XX from the supported code set -> that character, %0D and
// %0A -> newline, %0D%0A -> one newline; bad or cut-off escapes pass literally.
// A request passes through the input register, then is decoded into the
// result register. Throughput: one request per cycle while each yields at
// most one byte and the receiver is ready; a request that yields more bytes
// holds the result register until they drain, since the output side drains
// one byte per cycle while out_ready is high. The input register takes one
// more request while results are still draining.
// Reset clears the escape state and empties both registers; no output is pending.
// When the receiver stalls, the result register holds, then the input
// register fills, then in_ready drops.
module url_percent_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import upd_pkg::*;

    logic       inv_reg;
    logic       inv_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    state_t     state_reg;
    state_t     state_next;
    logic [7:0] digit_reg;
    logic [7:0] digit_next;
    res_t       res;
    logic       can_load;
    logic       consume;
    logic       in_take;

    assign consume  = inv_reg && can_load;
    assign in_ready = !inv_reg || can_load;
    assign in_take  = in_valid && in_ready;
    assign inv_next = in_take ? 1'b1 : (consume ? 1'b0 : inv_reg);

    upd_decode u_decode (
        .state      (state_reg),
        .digit      (digit_reg),
        .cur_byte   (byte_reg),
        .cur_last   (last_reg),
        .state_next (state_next),
        .digit_next (digit_next),
        .res        (res)
    );

    upd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inv_reg   <= 1'b0;
            state_reg <= ST_EMPTY;
        end else begin
            inv_reg <= inv_next;
            if (consume) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (consume) begin
            digit_reg <= digit_next;
        end
    end

endmodule
`default_nettype wire

[sv/upd_decode.sv]
`default_nettype none
module upd_decode (
    input  wire upd_pkg::state_t state,
    input  wire logic [7:0]      digit,
    input  wire logic [7:0]      cur_byte,
    input  wire logic            cur_last,
    output upd_pkg::state_t      state_next,
    output logic [7:0]           digit_next,
    output upd_pkg::res_t        res
);
    import upd_pkg::*;

    code_t  code;
    state_t fed;

    assign code = known_code(digit, cur_byte);

    // state after the byte, before any end-of-string flush
    always_comb
    begin
        fed        = ST_EMPTY;
        digit_next = digit;
        unique case (state)
            ST_EMPTY:
            begin
                fed = (cur_byte == CH_PCT) ? ST_PCT : ST_EMPTY;
            end
            ST_PCT:
            begin
                if (is_code_start(cur_byte)) begin
                    fed        = ST_PCT_D;
                    digit_next = cur_byte;
                end else begin
                    fed = (cur_byte == CH_PCT) ? ST_PCT : ST_EMPTY;
                end
            end
            ST_PCT_D:
            begin
                if (code.ok) begin
                    fed = (code.val == CH_CR) ? ST_NL : ST_EMPTY;
                end else begin
                    fed = (cur_byte == CH_PCT) ? ST_PCT : ST_EMPTY;
                end
            end
            ST_NL:
            begin
                fed = (cur_byte == CH_PCT) ? ST_NL_PCT : ST_EMPTY;
            end
            ST_NL_PCT:
            begin
                if (cur_byte == CH_ZERO) begin
                    fed = ST_NL_PCT0;
                end else if (is_code_start(cur_byte)) begin
                    fed        = ST_PCT_D;
                    digit_next = cur_byte;
                end else begin
                    fed = (cur_byte == CH_PCT) ? ST_PCT : ST_EMPTY;
                end
            end
            ST_NL_PCT0:
            begin
                if (cur_byte == CH_UC_A) begin
                    fed = ST_EMPTY;
                end else if (cur_byte == CH_UC_D) begin
                    fed = ST_NL;
                end else begin
                    fed = (cur_byte == CH_PCT) ? ST_PCT : ST_EMPTY;
                end
            end
            default:
            begin
                fed = ST_EMPTY;
            end
        endcase
        state_next = cur_last ? ST_EMPTY : fed;
    end

    always_comb
    begin
        res      = '0;
        res.last = cur_last;
        unique case (state)
            ST_EMPTY:
            begin
                if (cur_byte != CH_PCT) res = res_push(res, map_plain(cur_byte));
            end
            ST_PCT:
            begin
                if (!is_code_start(cur_byte)) begin
                    res = res_push(res, CH_PCT);
                    if (cur_byte != CH_PCT) res = res_push(res, map_plain(cur_byte));
                end
            end
            ST_PCT_D:
            begin
                if (code.ok) begin
                    if (code.val != CH_CR) res = res_push(res, code.val);
                end else begin
                    res = res_push(res, CH_PCT);
                    res = res_push(res, digit);
                    if (cur_byte != CH_PCT) res = res_push(res, map_plain(cur_byte));
                end
            end
            ST_NL:
            begin
                if (cur_byte != CH_PCT) begin
                    res = res_push(res, CH_NL);
                    res = res_push(res, map_plain(cur_byte));
                end
            end
            ST_NL_PCT:
            begin
                if (cur_byte != CH_ZERO) begin
                    res = res_push(res, CH_NL);
                    if (!is_code_start(cur_byte)) begin
                        res = res_push(res, CH_PCT);
                        if (cur_byte != CH_PCT) res = res_push(res, map_plain(cur_byte));
                    end
                end
            end
            ST_NL_PCT0:
            begin
                res = res_push(res, CH_NL);
                if (cur_byte != CH_UC_A && cur_byte != CH_UC_D) begin
                    res = res_push(res, CH_PCT);
                    res = res_push(res, CH_ZERO);
                    if (cur_byte != CH_PCT) res = res_push(res, map_plain(cur_byte));
                end
            end
            default:
            begin
                res.cnt = '0;
            end
        endcase

        // end of string: flush whatever is still pending
        if (cur_last) begin
            unique case (fed)
                ST_PCT:
                begin
                    res = res_push(res, CH_PCT);
                end
                ST_PCT_D:
                begin
                    res = res_push(res, CH_PCT);
                    res = res_push(res, digit_next);
                end
                ST_NL:
                begin
                    res = res_push(res, CH_NL);
                end
                ST_NL_PCT:
                begin
                    res = res_push(res, CH_NL);
                    res = res_push(res, CH_PCT);
                end
                ST_NL_PCT0:
                begin
                    res = res_push(res, CH_NL);
                    res = res_push(res, CH_PCT);
                    res = res_push(res, CH_ZERO);
                end
                default:
                begin
                    res.last = cur_last;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/upd_out_buf.sv]
`default_nettype none
module upd_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire upd_pkg::res_t  res,
    output logic                can_load,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import upd_pkg::*;

    logic [3:0][7:0] bytes_reg;
    logic [2:0]      cnt_reg;
    logic [2:0]      cnt_next;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;
    logic            last_reg;
    logic            take;

    assign out_valid = (cnt_reg != 3'd0);
    assign take      = out_valid && out_ready;
    assign can_load  = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ready);
    assign out_byte  = bytes_reg[idx_reg];
    assign out_last  = last_reg && (cnt_reg == 3'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = res.cnt;
            idx_next = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bytes_reg <= res.bytes;
            last_reg  <= res.last;
        end
    end

endmodule
`default_nettype wire
